// ===== rtl/crcd_pkg.sv =====
// ----------------------------------------------------------------------------
// crcd_pkg
// Shared types, codes and the byte-wide CRC-16 update for the frame deframer.
// ----------------------------------------------------------------------------
package crcd_pkg;

    localparam logic [15:0] CRC_SEED = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [7:0] SOF_FIRST_RST  = 8'hAA;
    localparam logic [7:0] SOF_SECOND_RST = 8'h55;
    localparam logic [7:0] VERSION_RST    = 8'h01;
    localparam logic [8:0] LIMIT_RST      = 9'd256;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_SOF_FIRST  = 2'd0,
        CFG_SOF_SECOND = 2'd1,
        CFG_VERSION    = 2'd2,
        CFG_LIMIT      = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        STAT_GOOD     = 2'd0,
        STAT_CRC_ERR  = 2'd1,
        STAT_BAD_VER  = 2'd2,
        STAT_TOO_LONG = 2'd3
    } t_status;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_EOF     = 1'b1
    } t_kind;

    // header byte positions counted from the first start byte
    localparam logic [2:0] HDR_VERSION = 3'd2;
    localparam logic [2:0] HDR_KIND    = 3'd3;
    localparam logic [2:0] HDR_SEQ_LO  = 3'd4;
    localparam logic [2:0] HDR_SEQ_HI  = 3'd5;
    localparam logic [2:0] HDR_LEN_LO  = 3'd6;
    localparam logic [2:0] HDR_LEN_HI  = 3'd7;

    typedef struct packed {
        logic [7:0] sof_first;
        logic [7:0] sof_second;
        logic [7:0] version;
        logic [8:0] limit;
    } t_cfg;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data;
        logic [7:0]  offset;
        t_status     status;
        logic [7:0]  fkind;
        logic [15:0] seq;
        logic [15:0] len;
    } t_result;

    // CRC-16, MSB first, one byte per call
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/crcd_cfg.sv =====
// ----------------------------------------------------------------------------
// crcd_cfg
// Configuration registers: start bytes, expected version, payload limit.
// ----------------------------------------------------------------------------
module crcd_cfg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_addr,
    input  logic [8:0]           i_cfg_wdata,
    output crcd_pkg::t_cfg       o_cfg
);
    import crcd_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sof_first  <= SOF_FIRST_RST;
            r_cfg.sof_second <= SOF_SECOND_RST;
            r_cfg.version    <= VERSION_RST;
            r_cfg.limit      <= LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_SOF_FIRST:  r_cfg.sof_first  <= i_cfg_wdata[7:0];
                CFG_SOF_SECOND: r_cfg.sof_second <= i_cfg_wdata[7:0];
                CFG_VERSION:    r_cfg.version    <= i_cfg_wdata[7:0];
                CFG_LIMIT:      r_cfg.limit      <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/crcd_core.sv =====
// ----------------------------------------------------------------------------
// crcd_core
// Frame parser: start-byte hunt, header capture and checks, payload pass,
// CRC trailer compare. One byte is consumed per accepted item.
// ----------------------------------------------------------------------------
module crcd_core #(
    parameter int MAX_PAYLOAD = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [7:0]           i_byte,
    input  crcd_pkg::t_cfg       i_cfg,
    output logic                 o_push,
    output crcd_pkg::t_result    o_res
);
    import crcd_pkg::*;

    localparam int          CLOG_W  = $clog2(MAX_PAYLOAD + 1);
    localparam int          CW      = (CLOG_W > 8) ? CLOG_W : 8;
    localparam logic [15:0] LIM_MAX = 16'(MAX_PAYLOAD);

    typedef enum logic [5:0] {
        ST_HUNT1 = 6'b000001,
        ST_HUNT2 = 6'b000010,
        ST_HDR   = 6'b000100,
        ST_PAY   = 6'b001000,
        ST_CRCLO = 6'b010000,
        ST_CRCHI = 6'b100000
    } t_state;

    t_state         r_state,  n_state;
    logic [2:0]     r_hpos,   n_hpos;
    logic [CW-1:0]  r_off,    n_off;
    logic [15:0]    r_crc,    n_crc;
    logic           r_ver_ok, n_ver_ok;
    logic [7:0]     r_kind,   n_kind;
    logic [15:0]    r_seq,    n_seq;
    logic [15:0]    r_len,    n_len;
    logic [7:0]     r_crc_lo, n_crc_lo;

    logic [15:0]    crc_upd;
    logic [15:0]    lim_eff;
    logic [15:0]    len_new;
    logic           pay_last;

    assign crc_upd  = crc_byte(r_crc, i_byte);
    assign lim_eff  = (16'(i_cfg.limit) > LIM_MAX) ? LIM_MAX : 16'(i_cfg.limit);
    assign len_new  = {i_byte, r_len[7:0]};
    assign pay_last = ((16'(r_off) + 16'd1) == r_len);

    always_comb begin
        n_state  = r_state;
        n_hpos   = r_hpos;
        n_off    = r_off;
        n_crc    = r_crc;
        n_ver_ok = r_ver_ok;
        n_kind   = r_kind;
        n_seq    = r_seq;
        n_len    = r_len;
        n_crc_lo = r_crc_lo;
        o_push   = 1'b0;
        o_res.kind   = KIND_PAYLOAD;
        o_res.data   = 8'h00;
        o_res.offset = 8'h00;
        o_res.status = STAT_GOOD;

        if (i_accept) begin
            unique case (r_state)
                ST_HUNT1: begin
                    if (i_byte == i_cfg.sof_first) begin
                        n_state = ST_HUNT2;
                    end
                end
                ST_HUNT2: begin
                    if (i_byte == i_cfg.sof_second) begin
                        n_state = ST_HDR;
                        n_hpos  = HDR_VERSION;
                        n_crc   = CRC_SEED;
                    end else if (i_byte != i_cfg.sof_first) begin
                        n_state = ST_HUNT1;
                    end
                end
                ST_HDR: begin
                    n_crc  = crc_upd;
                    n_hpos = r_hpos + 3'd1;
                    case (r_hpos)
                        HDR_VERSION: n_ver_ok = (i_byte == i_cfg.version);
                        HDR_KIND:    n_kind   = i_byte;
                        HDR_SEQ_LO:  n_seq    = {8'h00, i_byte};
                        HDR_SEQ_HI:  n_seq    = {i_byte, r_seq[7:0]};
                        HDR_LEN_LO:  n_len    = {8'h00, i_byte};
                        HDR_LEN_HI: begin
                            n_len = len_new;
                            // version error wins over length error
                            if (!r_ver_ok) begin
                                n_state      = ST_HUNT1;
                                o_push       = 1'b1;
                                o_res.kind   = KIND_EOF;
                                o_res.status = STAT_BAD_VER;
                            end else if (len_new > lim_eff) begin
                                n_state      = ST_HUNT1;
                                o_push       = 1'b1;
                                o_res.kind   = KIND_EOF;
                                o_res.status = STAT_TOO_LONG;
                            end else begin
                                n_off   = '0;
                                n_state = (len_new == 16'd0) ? ST_CRCLO : ST_PAY;
                            end
                        end
                        default: ;
                    endcase
                end
                ST_PAY: begin
                    n_crc        = crc_upd;
                    n_off        = r_off + CW'(1);
                    o_push       = 1'b1;
                    o_res.data   = i_byte;
                    o_res.offset = r_off[7:0];
                    if (pay_last) begin
                        n_state = ST_CRCLO;
                    end
                end
                ST_CRCLO: begin
                    n_crc_lo = i_byte;
                    n_state  = ST_CRCHI;
                end
                ST_CRCHI: begin
                    n_state      = ST_HUNT1;
                    o_push       = 1'b1;
                    o_res.kind   = KIND_EOF;
                    o_res.status = ({i_byte, r_crc_lo} == r_crc) ? STAT_GOOD : STAT_CRC_ERR;
                end
                default: n_state = ST_HUNT1;
            endcase
        end

        o_res.fkind = n_kind;
        o_res.seq   = n_seq;
        o_res.len   = n_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_HUNT1;
            r_hpos   <= HDR_VERSION;
            r_off    <= '0;
            r_crc    <= CRC_SEED;
            r_ver_ok <= 1'b0;
            r_kind   <= 8'h00;
            r_seq    <= 16'h0000;
            r_len    <= 16'h0000;
            r_crc_lo <= 8'h00;
        end else begin
            r_state  <= n_state;
            r_hpos   <= n_hpos;
            r_off    <= n_off;
            r_crc    <= n_crc;
            r_ver_ok <= n_ver_ok;
            r_kind   <= n_kind;
            r_seq    <= n_seq;
            r_len    <= n_len;
            r_crc_lo <= n_crc_lo;
        end
    end

endmodule

// ===== rtl/crcd_obuf.sv =====
// ----------------------------------------------------------------------------
// crcd_obuf
// Result register with a skid entry; upstream ready comes from a register.
// ----------------------------------------------------------------------------
module crcd_obuf (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  crcd_pkg::t_result    i_data,
    output logic                 o_ready,
    output logic                 o_valid,
    input  logic                 i_ready,
    output crcd_pkg::t_result    o_data
);
    import crcd_pkg::*;

    logic    r_main_v, n_main_v;
    logic    r_skid_v, n_skid_v;
    t_result r_main,   n_main;
    t_result r_skid,   n_skid;
    logic    pop;

    assign pop = r_main_v & i_ready;

    always_comb begin
        n_main_v = r_main_v;
        n_skid_v = r_skid_v;
        n_main   = r_main;
        n_skid   = r_skid;
        if (pop && r_skid_v) begin
            // advance skid into the output slot
            n_main   = r_skid;
            n_skid_v = 1'b0;
        end else if (pop || !r_main_v) begin
            n_main_v = i_push;
            n_main   = i_data;
        end else if (i_push) begin
            // output held, park the new item
            n_skid_v = 1'b1;
            n_skid   = i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_main_v <= n_main_v;
            r_skid_v <= n_skid_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_main <= n_main;
        r_skid <= n_skid;
    end

    assign o_ready = !r_skid_v;
    assign o_valid = r_main_v;
    assign o_data  = r_main;

endmodule

// ===== rtl/crc_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// crc_frame_deframer
// Byte-stream deframer: start-byte hunt, 8-byte header, payload pass-through
// and CRC-16 trailer check, with one end-of-frame record per frame.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  rx        in         i_rx_valid / o_rx_ready    i_rx_byte
//  rec       out        o_rec_valid / i_rec_ready  o_record_kind .. o_frame_payload_length
//  cfg       in         i_cfg_we                   i_cfg_addr, i_cfg_wdata
//
// One byte is taken per cycle while rx ready is high; the header, payload and
// CRC update all finish in the cycle the byte is accepted, and each record is
// registered in the output stage. Throughput is set by the parser's byte-wide CRC update.
// A two-entry output stage absorbs sink stalls; rx ready drops only when both
// entries are full. Reset is synchronous and returns the parser to the hunt.
// ----------------------------------------------------------------------------
module crc_frame_deframer #(
    parameter int MAX_PAYLOAD = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [8:0]  i_cfg_wdata,
    input  logic        i_rx_valid,
    output logic        o_rx_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_rec_valid,
    input  logic        i_rec_ready,
    output logic        o_record_kind,
    output logic [7:0]  o_payload_data,
    output logic [7:0]  o_payload_offset,
    output logic [1:0]  o_frame_status,
    output logic [7:0]  o_frame_kind,
    output logic [15:0] o_frame_sequence,
    output logic [15:0] o_frame_payload_length
);
    import crcd_pkg::*;

    t_cfg    cfg;
    t_result res;
    t_result rec;
    logic    push;
    logic    accept;

    assign accept = i_rx_valid & o_rx_ready;

    crcd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    crcd_core #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_rx_byte),
        .i_cfg    (cfg),
        .o_push   (push),
        .o_res    (res)
    );

    crcd_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (res),
        .o_ready (o_rx_ready),
        .o_valid (o_rec_valid),
        .i_ready (i_rec_ready),
        .o_data  (rec)
    );

    assign o_record_kind          = rec.kind;
    assign o_payload_data         = rec.data;
    assign o_payload_offset       = rec.offset;
    assign o_frame_status         = rec.status;
    assign o_frame_kind           = rec.fkind;
    assign o_frame_sequence       = rec.seq;
    assign o_frame_payload_length = rec.len;

endmodule
